@@ rtl/opm_pkg.sv @@
// Package for the optical pulse power meter.
// Field widths, power constants, register reset values, register indexes, item kinds and divider status.
// No dependencies.
`default_nettype none

package opm_pkg;

    // Field widths
    localparam int SAMPLE_W   = 10;
    localparam int TIME_W     = 32;
    localparam int MIN_INT_W  = 16;
    localparam int POWER_W    = 22;
    localparam int COUNT_W    = 32;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    // Stream payload widths (byte padded)
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 56;

    // Power numerator: 0.1 Wh per pulse, ms interval -> tenths of a watt
    localparam logic [POWER_W-1:0] POWER_SCALE = POWER_W'(3600000);
    localparam logic [POWER_W-1:0] POWER_MAX   = POWER_W'(3600000);

    // One quotient bit per divider step
    localparam int DIV_STEPS = POWER_W;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS);

    // Register reset values
    localparam logic [SAMPLE_W-1:0]  HIGH_THR_RST = SAMPLE_W'(600);
    localparam logic [SAMPLE_W-1:0]  LOW_THR_RST  = SAMPLE_W'(400);
    localparam logic [TIME_W-1:0]    TIMEOUT_RST  = TIME_W'(60000);
    localparam logic [MIN_INT_W-1:0] MIN_INT_RST  = MIN_INT_W'(50);

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_HIGH_THR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LOW_THR  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_INT  = 2'd3;

    // Input item kinds
    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_IDLE   = 1'b1;

    // Divider status toward the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } div_status_t;

endpackage

`default_nettype wire

@@ rtl/opm_divider.sv @@
// Iterative radix-2 restoring divider: fixed numerator POWER_SCALE over a
// 32-bit divisor, one quotient bit per cycle. Depends on opm_pkg.
`default_nettype none

module opm_divider
    import opm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic [TIME_W-1:0]  divisor,   // held stable while busy
    output div_status_t             status,
    output logic      [POWER_W-1:0] quotient
);

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [TIME_W-1:0]    rem_reg, rem_next;
    logic [POWER_W-1:0]   quo_reg, quo_next;

    logic [TIME_W:0]      trial;
    logic [TIME_W:0]      diff;
    logic                 fits;

    // One restoring step: bring down the next numerator bit, try subtract
    always_comb
    begin
        trial = {rem_reg, quo_reg[POWER_W-1]};
        diff  = trial - {1'b0, divisor};
        fits  = (trial >= {1'b0, divisor});
    end

    // Step sequencing
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = POWER_SCALE;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[TIME_W-1:0] : trial[TIME_W-1:0];
            quo_next = {quo_reg[POWER_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_CNT_W'(DIV_STEPS - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath, no reset
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign quotient    = quo_reg;

endmodule

`default_nettype wire

@@ rtl/optical_pulse_power_meter.sv @@
// Optical pulse power meter top level: config registers, hysteresis and
// pulse sequencer, output register. Depends on opm_pkg and opm_divider.
`default_nettype none
//
//  Channel  Dir  Handshake          Payload (low bit first)
//  s_*      in   s_tvalid/s_tready  tuser: operation; tdata: sample, now_ms
//  m_*      out  m_tvalid/m_tready  tdata: power, pulse_count, pulse_detected, in_flash
//  cfg_*    in   cfg_we             cfg_index, cfg_data
//
//  An item passes from accept through the EVAL, CHECK and DONE states to the
//  output register, and a new item is taken only back in IDLE; a pulse that
//  updates power also waits in ST_DIV on the 22-step shared divider (one
//  quotient bit per cycle). s_tready is high only while the sequencer is idle.
//  Reset clears the hysteresis, pulse state, count, power and restores the
//  register defaults. A stalled result is held in the output register; the
//  next item may be taken meanwhile and waits in its last step.

module optical_pulse_power_meter
    import opm_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    // Input items
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // sample[9:0], now_ms[41:10], zero pad
    input  wire logic                  s_tuser,   // operation
    // Result items
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_TDATA_W-1:0]  m_tdata,   // power[21:0], count[53:22],
                                                  // pulse_detected[54], in_flash[55]
    // Configuration writes
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // Sequencer states
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EVAL  = 3'd1;
    localparam logic [2:0] ST_CHECK = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_DONE  = 3'd4;

    // Configuration
    logic [SAMPLE_W-1:0]  high_thr_reg;
    logic [SAMPLE_W-1:0]  low_thr_reg;
    logic [TIME_W-1:0]    timeout_reg;
    logic [MIN_INT_W-1:0] min_int_reg;

    // Control and meter state
    logic [2:0]           state_reg, state_next;
    logic                 flashing_reg, flashing_next;
    logic                 have_pulse_reg, have_pulse_next;
    logic [TIME_W-1:0]    last_time_reg, last_time_next;
    logic [POWER_W-1:0]   power_reg, power_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic                 out_valid_reg, out_valid_next;

    // Captured item and scratch
    logic                 op_reg;
    logic [SAMPLE_W-1:0]  sample_reg;
    logic [TIME_W-1:0]    now_reg;
    logic                 rise_reg, rise_next;
    logic [TIME_W-1:0]    interval_reg, interval_next;
    logic [M_TDATA_W-1:0] out_data_reg;

    logic                 in_accept;
    logic                 out_free;
    logic                 div_start;
    div_status_t          div_status;
    logic [POWER_W-1:0]   div_quotient;

    assign in_accept = s_tvalid && s_tready;
    assign out_free  = !out_valid_reg || m_tready;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_thr_reg <= HIGH_THR_RST;
            low_thr_reg  <= LOW_THR_RST;
            timeout_reg  <= TIMEOUT_RST;
            min_int_reg  <= MIN_INT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HIGH_THR: high_thr_reg <= cfg_data[SAMPLE_W-1:0];
                REG_LOW_THR:  low_thr_reg  <= cfg_data[SAMPLE_W-1:0];
                REG_TIMEOUT:  timeout_reg  <= cfg_data[TIME_W-1:0];
                REG_MIN_INT:  min_int_reg  <= cfg_data[MIN_INT_W-1:0];
                default:      ;
            endcase
        end
    end

    // Shared divider: POWER_SCALE / interval
    opm_divider u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .divisor  (interval_reg),
        .status   (div_status),
        .quotient (div_quotient)
    );

    // Sequencer
    always_comb
    begin
        state_next      = state_reg;
        flashing_next   = flashing_reg;
        have_pulse_next = have_pulse_reg;
        last_time_next  = last_time_reg;
        power_next      = power_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg;
        rise_next       = rise_reg;
        interval_next   = interval_reg;
        div_start       = 1'b0;

        if (out_valid_reg && m_tready)
            out_valid_next = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept)
                    state_next = ST_EVAL;
            end
            // Edge detect and interval since the last pulse
            ST_EVAL:
            begin
                rise_next     = (op_reg == OP_SAMPLE) && (sample_reg > high_thr_reg)
                                && !flashing_reg;
                interval_next = now_reg - last_time_reg;
                state_next    = ST_CHECK;
            end
            // Update pulse state, decide on a power update
            ST_CHECK:
            begin
                state_next = ST_DONE;
                if (op_reg == OP_IDLE)
                begin
                    if (have_pulse_reg && (interval_reg > timeout_reg))
                        power_next = '0;
                end
                else
                begin
                    if (rise_reg)
                    begin
                        if (have_pulse_reg && (interval_reg > TIME_W'(min_int_reg))
                            && (interval_reg != '0))
                        begin
                            div_start  = 1'b1;
                            state_next = ST_DIV;
                        end
                        last_time_next  = now_reg;
                        have_pulse_next = 1'b1;
                        flashing_next   = 1'b1;
                        count_next      = count_reg + 1'b1;
                    end
                    if (sample_reg < low_thr_reg)
                        flashing_next = 1'b0;
                end
            end
            // Quotient never exceeds POWER_MAX since the interval is at least 1
            ST_DIV:
            begin
                if (div_status.done)
                begin
                    power_next = (div_quotient > POWER_MAX) ? POWER_MAX : div_quotient;
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            flashing_reg   <= 1'b0;
            have_pulse_reg <= 1'b0;
            last_time_reg  <= '0;
            power_reg      <= '0;
            count_reg      <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            flashing_reg   <= flashing_next;
            have_pulse_reg <= have_pulse_next;
            last_time_reg  <= last_time_next;
            power_reg      <= power_next;
            count_reg      <= count_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Item capture and scratch, no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            op_reg     <= s_tuser;
            sample_reg <= s_tdata[SAMPLE_W-1:0];
            now_reg    <= s_tdata[SAMPLE_W+TIME_W-1:SAMPLE_W];
        end
        rise_reg     <= rise_next;
        interval_reg <= interval_next;
        if ((state_reg == ST_DONE) && out_free)
            out_data_reg <= {flashing_reg, rise_reg, count_reg, power_reg};
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

@@ rtl/opm_checker.sv @@
// Port-level checks for the optical pulse power meter, bound to the top.
// Depends on opm_pkg and optical_pulse_power_meter.
`default_nettype none

module opm_checker
    import opm_pkg::*;
(
    input wire logic                 clk,
    input wire logic                 rst_n,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata
);

    // A held result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    // A held result keeps its payload
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    // One item at a time: the input closes right after an accept
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while an item is in work");

    // Power never passes its ceiling
    a_power_max: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[POWER_W-1:0] <= POWER_MAX))
        else $error("power above ceiling");

endmodule

bind optical_pulse_power_meter opm_checker u_opm_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
